>>> rtl/core/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types, constants and the reaction table of the stochastic
// reaction step block.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int unsigned COUNT_BITS     = 16;
  localparam int unsigned RATE_FRAC_BITS = 16;
  localparam int unsigned NUM_REACTIONS  = 22;
  localparam int unsigned NUM_SPECIES    = 6;
  localparam int unsigned NUM_RATES      = 6;
  localparam int unsigned PROP_W         = 42;
  localparam int unsigned OPA_W          = 48;
  localparam int unsigned OPB_W          = 32;
  localparam int unsigned PROD_W         = 64;
  localparam int unsigned DIV_W          = 48;

  localparam logic [2:0]        NO_FACTOR = 3'd6;
  localparam logic [PROD_W-1:0] PROP_CAP  = (64'd1 << PROP_W) - 64'd1;
  localparam logic [15:0]       LN2_Q16   = 16'd45426;

  // configuration register indexes
  localparam logic [2:0] REG_KAPPA    = 3'd0;
  localparam logic [2:0] REG_OMEGA    = 3'd1;
  localparam logic [2:0] REG_GAMMA    = 3'd2;
  localparam logic [2:0] REG_SIGMA    = 3'd3;
  localparam logic [2:0] REG_EPSILON  = 3'd4;
  localparam logic [2:0] REG_DELTA    = 3'd5;
  localparam logic [2:0] REG_CAPACITY = 3'd6;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic [2:0]      rate;
    logic [2:0][2:0] f;
    logic [1:0]      cc_pow;
    logic [2:0]      species;
    logic            up;
  } rxn_t;

  typedef struct packed {
    logic             start;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    MP_IDLE = 3'b001,
    MP_LO   = 3'b010,
    MP_HI   = 3'b100
  } mul_phase_e;

  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_PINIT  = 19'h00002,
    ST_PFAC   = 19'h00004,
    ST_PMULW  = 19'h00008,
    ST_PDIV   = 19'h00010,
    ST_PDIVW  = 19'h00020,
    ST_PACC   = 19'h00040,
    ST_SMUL   = 19'h00080,
    ST_SMULW  = 19'h00100,
    ST_SCAN   = 19'h00200,
    ST_APPLY  = 19'h00400,
    ST_LNORM  = 19'h00800,
    ST_LSQ    = 19'h01000,
    ST_LSQW   = 19'h02000,
    ST_LSC    = 19'h04000,
    ST_LSCW   = 19'h08000,
    ST_TDIV   = 19'h10000,
    ST_TDIVW  = 19'h20000,
    ST_FIN    = 19'h40000
  } seq_state_e;

  function automatic rxn_t mk(input logic [2:0] rate, input logic [2:0] f0,
                              input logic [2:0] f1, input logic [2:0] f2,
                              input logic [1:0] pw, input logic [2:0] sp,
                              input logic up);
    rxn_t r;
    r.rate    = rate;
    r.f       = {f2, f1, f0};
    r.cc_pow  = pw;
    r.species = sp;
    r.up      = up;
    return r;
  endfunction

  // reaction table: rate, three factors, capacity power, species, direction
  function automatic rxn_t rxn_lookup(input logic [4:0] idx);
    rxn_t r;
    case (idx)
      5'd0:    r = mk(3'd0, 3'd0, 3'd2, NO_FACTOR, 2'd1, 3'd0, 1'b1);
      5'd1:    r = mk(3'd0, 3'd0, 3'd0, 3'd2,      2'd2, 3'd0, 1'b0);
      5'd2:    r = mk(3'd0, 3'd0, 3'd1, 3'd2,      2'd2, 3'd0, 1'b0);
      5'd3:    r = mk(3'd4, 3'd0, 3'd3, NO_FACTOR, 2'd1, 3'd0, 1'b0);
      5'd4:    r = mk(3'd2, 3'd0, NO_FACTOR, NO_FACTOR, 2'd0, 3'd0, 1'b0);
      5'd5:    r = mk(3'd0, 3'd1, 3'd2, NO_FACTOR, 2'd1, 3'd1, 1'b1);
      5'd6:    r = mk(3'd0, 3'd1, 3'd1, 3'd2,      2'd2, 3'd1, 1'b0);
      5'd7:    r = mk(3'd0, 3'd0, 3'd1, 3'd2,      2'd2, 3'd1, 1'b0);
      5'd8:    r = mk(3'd4, 3'd1, 3'd3, NO_FACTOR, 2'd1, 3'd1, 1'b0);
      5'd9:    r = mk(3'd2, 3'd1, NO_FACTOR, NO_FACTOR, 2'd0, 3'd1, 1'b0);
      5'd10:   r = mk(3'd1, 3'd0, NO_FACTOR, NO_FACTOR, 2'd0, 3'd2, 1'b1);
      5'd11:   r = mk(3'd1, 3'd0, 3'd2, NO_FACTOR, 2'd1, 3'd2, 1'b0);
      5'd12:   r = mk(3'd1, 3'd0, 3'd3, NO_FACTOR, 2'd1, 3'd2, 1'b0);
      5'd13:   r = mk(3'd3, 3'd2, NO_FACTOR, NO_FACTOR, 2'd0, 3'd2, 1'b0);
      5'd14:   r = mk(3'd1, 3'd1, NO_FACTOR, NO_FACTOR, 2'd0, 3'd3, 1'b1);
      5'd15:   r = mk(3'd1, 3'd1, 3'd2, NO_FACTOR, 2'd1, 3'd3, 1'b0);
      5'd16:   r = mk(3'd1, 3'd1, 3'd3, NO_FACTOR, 2'd1, 3'd3, 1'b0);
      5'd17:   r = mk(3'd3, 3'd3, NO_FACTOR, NO_FACTOR, 2'd0, 3'd3, 1'b0);
      5'd18:   r = mk(3'd4, 3'd0, 3'd3, NO_FACTOR, 2'd1, 3'd4, 1'b1);
      5'd19:   r = mk(3'd5, 3'd4, NO_FACTOR, NO_FACTOR, 2'd0, 3'd4, 1'b0);
      5'd20:   r = mk(3'd4, 3'd1, 3'd3, NO_FACTOR, 2'd1, 3'd5, 1'b1);
      5'd21:   r = mk(3'd5, 3'd5, NO_FACTOR, NO_FACTOR, 2'd0, 3'd5, 1'b0);
      default: r = mk(3'd0, NO_FACTOR, NO_FACTOR, NO_FACTOR, 2'd0, 3'd0, 1'b0);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/stochastic_reaction_step.sv
// ----------------------------------------------------------------------------
// stochastic_reaction_step
// Gillespie direct-method step for a fixed 22-reaction, six-species network.
// ----------------------------------------------------------------------------
// A start transfer (tuser 0) loads the two RNA counts, clears time and the
// other counts and goes straight to the output stage. A step transfer
// (tuser 1) runs all work through one shared multiplier and one bit-serial
// divider: each of the 22 propensities takes up to three products and up to
// two divisions by the capacity, then come the selection product, a scan over
// up to 22 reactions, sixteen squarings for the logarithm and the final
// division for the waiting time, 19 divisions in all at most. A step whose
// total propensity is zero ends after the propensities. The block takes no
// new item while a step is in progress; results are held in an output
// register until taken.
// ----------------------------------------------------------------------------
module stochastic_reaction_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  // config write port
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // init_rna_one, init_rna_two, rand_time, rand_pick
  input  logic [63:0]   s_axis_tdata,
  // command
  input  logic          s_axis_tuser,
  // output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // sim_time, count_rna_one, count_rna_two, count_replicase, count_coat,
  // count_virion_one, count_virion_two, fired_reaction, rna_extinct, zero pad
  output logic [135:0]  m_axis_tdata
);
  import srs_pkg::*;

  seq_state_e state_q, state_d;

  logic [31:0]           rates_q [NUM_RATES];
  logic [15:0]           cap_q;
  logic [COUNT_BITS-1:0] cnt_q [NUM_SPECIES];
  logic [31:0]           time_q;

  logic                  cmd_q;
  logic [15:0]           pick_in_q;
  logic [15:0]           u_q;
  logic [3:0]            s_q;
  logic [30:0]           y_q;
  logic [15:0]           f_q;
  logic [3:0]            it_q;
  logic [20:0]           ln_q;

  logic [4:0]            idx_q;
  logic [1:0]            fac_q;
  logic [1:0]            pow_q;
  logic [PROP_W-1:0]     v_q;
  logic [PROP_W-1:0]     w_q [NUM_REACTIONS];
  logic [DIV_W-1:0]      total_q;
  logic [DIV_W-1:0]      target_q;
  logic [DIV_W-1:0]      prefix_q;
  logic [4:0]            fired_q;

  logic                  m_valid_q;
  logic [135:0]          m_data_q;

  rxn_t                  rx;
  logic [2:0]            fac_sel;
  logic [COUNT_BITS-1:0] fac_cnt;
  logic [15:0]           cc_eff;
  logic [DIV_W-1:0]      prefix_n;
  logic [31:0]           ysq;
  logic [20:0]           neg;
  logic [32:0]           tsum;
  logic                  in_acc;
  logic                  out_load;

  mul_req_t              mul_req;
  logic                  mul_done;
  logic [PROD_W-1:0]     mul_prod;
  div_req_t              div_req;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;

  assign rx       = rxn_lookup(idx_q);
  assign cc_eff   = (cap_q == 16'd0) ? 16'd1 : cap_q;
  assign prefix_n = prefix_q + {6'b0, w_q[idx_q]};
  assign ysq      = mul_prod[61:30];
  assign neg      = {5'({1'b0, s_q} + 5'd1), 16'b0} - {5'b0, f_q};
  assign tsum     = {1'b0, time_q} + {1'b0, div_quot[31:0]};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

  // factor of the current propensity term
  always_comb begin
    case (fac_q)
      2'd0:    fac_sel = rx.f[0];
      2'd1:    fac_sel = rx.f[1];
      2'd2:    fac_sel = rx.f[2];
      default: fac_sel = NO_FACTOR;
    endcase
    fac_cnt = (fac_sel < 3'(NUM_SPECIES)) ? cnt_q[fac_sel] : '0;
  end

  // requests to the shared units
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_q)
      ST_PFAC: begin
        mul_req.start = (fac_q != 2'd3) && (fac_sel != NO_FACTOR);
        mul_req.a     = {6'b0, v_q};
        mul_req.b     = {16'b0, fac_cnt};
      end
      ST_SMUL: begin
        mul_req.start = (total_q != '0);
        mul_req.a     = total_q;
        mul_req.b     = {16'b0, pick_in_q};
      end
      ST_LSQ: begin
        mul_req.start = 1'b1;
        mul_req.a     = {17'b0, y_q};
        mul_req.b     = {1'b0, y_q};
      end
      ST_LSC: begin
        mul_req.start = 1'b1;
        mul_req.a     = {27'b0, neg};
        mul_req.b     = {16'b0, LN2_Q16};
      end
      ST_PDIV: begin
        div_req.start    = (pow_q != 2'd0);
        div_req.dividend = {6'b0, v_q};
        div_req.divisor  = {32'b0, cc_eff};
      end
      ST_TDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {11'b0, ln_q, 16'b0};
        div_req.divisor  = total_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = (s_axis_tuser == CMD_START) ? ST_FIN : ST_PINIT;
      ST_PINIT: state_d = ST_PFAC;
      ST_PFAC: begin
        if (fac_q == 2'd3)             state_d = ST_PDIV;
        else if (fac_sel != NO_FACTOR) state_d = ST_PMULW;
      end
      ST_PMULW: if (mul_done) state_d = ST_PFAC;
      ST_PDIV:  state_d = (pow_q != 2'd0) ? ST_PDIVW : ST_PACC;
      ST_PDIVW: if (div_done) state_d = ST_PDIV;
      ST_PACC:  state_d = (idx_q == 5'(NUM_REACTIONS - 1)) ? ST_SMUL : ST_PINIT;
      ST_SMUL:  state_d = (total_q == '0) ? ST_FIN : ST_SMULW;
      ST_SMULW: if (mul_done) state_d = ST_SCAN;
      ST_SCAN: begin
        if (target_q < prefix_n || idx_q == 5'(NUM_REACTIONS - 1)) state_d = ST_APPLY;
      end
      ST_APPLY: state_d = ST_LNORM;
      ST_LNORM: if (u_q[15]) state_d = ST_LSQ;
      ST_LSQ:   state_d = ST_LSQW;
      ST_LSQW:  if (mul_done) state_d = (it_q == 4'd15) ? ST_LSC : ST_LSQ;
      ST_LSC:   state_d = ST_LSCW;
      ST_LSCW:  if (mul_done) state_d = ST_TDIV;
      ST_TDIV:  state_d = ST_TDIVW;
      ST_TDIVW: if (div_done) state_d = ST_FIN;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control, configuration and simulation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rates_q[0] <= 32'd65536;
      rates_q[1] <= 32'd65536;
      rates_q[2] <= 32'd0;
      rates_q[3] <= 32'd6554;
      rates_q[4] <= 32'd6554;
      rates_q[5] <= 32'd6554;
      cap_q      <= 16'd1000;
      time_q     <= '0;
      for (int i = 0; i < NUM_SPECIES; i++) cnt_q[i] <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KAPPA:    rates_q[0] <= cfg_data_i;
          REG_OMEGA:    rates_q[1] <= cfg_data_i;
          REG_GAMMA:    rates_q[2] <= cfg_data_i;
          REG_SIGMA:    rates_q[3] <= cfg_data_i;
          REG_EPSILON:  rates_q[4] <= cfg_data_i;
          REG_DELTA:    rates_q[5] <= cfg_data_i;
          REG_CAPACITY: cap_q      <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // start command loads the run
      if (in_acc && s_axis_tuser == CMD_START) begin
        for (int i = 2; i < NUM_SPECIES; i++) cnt_q[i] <= '0;
        cnt_q[0] <= s_axis_tdata[15:0];
        cnt_q[1] <= s_axis_tdata[31:16];
        time_q   <= '0;
      end
      // saturating count update of the fired reaction
      if (state_q == ST_APPLY) begin
        if (rx.up) begin
          if (cnt_q[rx.species] != '1) cnt_q[rx.species] <= cnt_q[rx.species] + 1'b1;
        end else begin
          if (cnt_q[rx.species] != '0) cnt_q[rx.species] <= cnt_q[rx.species] - 1'b1;
        end
      end
      // saturating time advance
      if (state_q == ST_TDIVW && div_done) begin
        time_q <= ((|div_quot[DIV_W-1:32]) || tsum[32]) ? '1 : tsum[31:0];
      end
      if (out_load)                        m_valid_q <= 1'b1;
      else if (m_axis_tready)              m_valid_q <= 1'b0;
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_q     <= s_axis_tuser;
          pick_in_q <= s_axis_tdata[63:48];
          u_q       <= (s_axis_tdata[47:32] == 16'd0) ? 16'd1 : s_axis_tdata[47:32];
          s_q       <= '0;
          idx_q     <= '0;
          total_q   <= '0;
          fired_q   <= '0;
        end
      end
      ST_PINIT: begin
        v_q   <= {10'b0, rates_q[rx.rate]};
        fac_q <= '0;
        pow_q <= rx.cc_pow;
      end
      ST_PFAC: begin
        if (fac_q != 2'd3 && fac_sel == NO_FACTOR) fac_q <= fac_q + 2'd1;
      end
      ST_PMULW: begin
        if (mul_done) begin
          v_q   <= (mul_prod > PROP_CAP) ? PROP_CAP[PROP_W-1:0] : mul_prod[PROP_W-1:0];
          fac_q <= fac_q + 2'd1;
        end
      end
      ST_PDIVW: begin
        if (div_done) begin
          v_q   <= div_quot[PROP_W-1:0];
          pow_q <= pow_q - 2'd1;
        end
      end
      ST_PACC: begin
        w_q[idx_q] <= v_q;
        total_q    <= total_q + {6'b0, v_q};
        if (idx_q != 5'(NUM_REACTIONS - 1)) idx_q <= idx_q + 5'd1;
      end
      ST_SMULW: begin
        if (mul_done) begin
          target_q <= mul_prod[63:16];
          prefix_q <= '0;
          idx_q    <= '0;
        end
      end
      ST_SCAN: begin
        prefix_q <= prefix_n;
        if (!(target_q < prefix_n) && idx_q != 5'(NUM_REACTIONS - 1)) idx_q <= idx_q + 5'd1;
      end
      ST_APPLY: fired_q <= idx_q + 5'd1;
      // normalise r1 into the top bit
      ST_LNORM: begin
        if (u_q[15]) begin
          y_q  <= {u_q, 15'b0};
          f_q  <= '0;
          it_q <= '0;
        end else begin
          u_q <= {u_q[14:0], 1'b0};
          s_q <= s_q + 4'd1;
        end
      end
      // one log2 fraction bit per squaring
      ST_LSQW: begin
        if (mul_done) begin
          y_q  <= ysq[31] ? ysq[31:1] : ysq[30:0];
          f_q  <= {f_q[14:0], ysq[31]};
          it_q <= it_q + 4'd1;
        end
      end
      ST_LSCW: if (mul_done) ln_q <= mul_prod[36:16];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {2'b0,
                   (cnt_q[0] == '0 && cnt_q[1] == '0),
                   (cmd_q == CMD_STEP) ? fired_q : 5'd0,
                   cnt_q[5], cnt_q[4], cnt_q[3], cnt_q[2], cnt_q[1], cnt_q[0],
                   time_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  srs_mul_unit u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  srs_div_unit u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

`ifndef SYNTHESIS
  // extinct flag agrees with the reported RNA counts
  a_extinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[133] ==
      (m_axis_tdata[47:32] == 16'd0 && m_axis_tdata[63:48] == 16'd0)))
    else $error("extinct flag mismatch");
  // no second transfer accepted straight after one
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");
  // reported reaction index stays in range
  a_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[132:128] <= 5'd22))
    else $error("fired reaction out of range");
`endif

endmodule

>>> rtl/core/srs_mul_unit.sv
// ----------------------------------------------------------------------------
// srs_mul_unit
// Shared 32x32 multiplier, used twice per request for a 48x32 product.
// ----------------------------------------------------------------------------
module srs_mul_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srs_pkg::mul_req_t             req_i,
  output logic                          done_o,
  output logic [srs_pkg::PROD_W-1:0]    prod_o
);
  import srs_pkg::*;

  mul_phase_e        phase_q, phase_d;
  logic [OPA_W-1:0]  a_q;
  logic [OPB_W-1:0]  b_q;
  logic [PROD_W-1:0] acc_q;
  logic              done_q;
  logic [31:0]       opa;
  logic [63:0]       m;

  // low word first, then the high part of the wide operand
  assign opa = (phase_q == MP_HI) ? {16'b0, a_q[OPA_W-1:32]} : a_q[31:0];
  assign m   = opa * b_q;

  always_comb begin
    case (phase_q)
      MP_IDLE: phase_d = req_i.start ? MP_LO : MP_IDLE;
      MP_LO:   phase_d = MP_HI;
      MP_HI:   phase_d = MP_IDLE;
      default: phase_d = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MP_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == MP_HI);
    end
  end

  // operand capture and partial product accumulation
  always_ff @(posedge clk_i) begin
    if (phase_q == MP_IDLE && req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    if (phase_q == MP_LO) begin
      acc_q <= m;
    end else if (phase_q == MP_HI) begin
      acc_q <= acc_q + {m[31:0], 32'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> rtl/core/srs_div_unit.sv
// ----------------------------------------------------------------------------
// srs_div_unit
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srs_div_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  srs_pkg::div_req_t          req_i,
  output logic                       done_o,
  output logic [srs_pkg::DIV_W-1:0]  quot_o
);
  import srs_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [5:0]       cnt_q;
  logic [DIV_W:0]   rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W-1:0] dvs_q;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift one dividend bit into the remainder per cycle
  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
